// File: rtl/timed_ip_ban_table_top_assert.svh
// Assertion macros for the ban table RTL.
`ifndef TIMED_IP_BAN_TABLE_TOP_ASSERT_SVH
`define TIMED_IP_BAN_TABLE_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define IBT_ASSERT(name, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("ibt assertion failed");

// Check a property on every clock edge, reset included.
`define IBT_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge aclk) prop) \
        else $error("ibt assertion failed");

`endif

// File: rtl/ibt_pkg.sv
// Types and constants for the timed IP ban table.
package ibt_pkg;

    localparam int TABLE_ENTRIES = 64;

    localparam logic OP_BAN    = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] address;
        logic [30:0] duration;
        logic [31:0] now_seconds;
    } in_t;

    typedef struct packed {
        logic is_banned;
        logic was_updated;
        logic table_full;
    } out_t;

    // Item walking the cell chain; stamp holds the end time on a ban
    // and the current time on a lookup.
    typedef struct packed {
        logic        valid;
        logic        opcode;
        logic [31:0] address;
        logic [32:0] stamp;
        logic        hit;
        logic        updated;
        logic        banned;
    } tok_t;

endpackage

// File: rtl/timed_ip_ban_table_top.sv
// Each item walks the chain of TABLE_ENTRIES cells one cell per cycle; a new item is
//   taken only once the last one has left the chain.
// A finished result may wait on m_ready while the next item is taken.
// Reset: synchronous, active low; clears all entry valid bits at once, with
//   no clearing pass; entry addresses and end times are left as they are.
`include "timed_ip_ban_table_top_assert.svh"

module timed_ip_ban_table_top
    import ibt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    tok_t                     chain [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] valid_vec;
    logic [TABLE_ENTRIES:0]   tok_vld;

    tok_t in_tok_reg;
    tok_t in_tok_next;
    logic busy_reg;
    logic pend_valid_reg;
    out_t pend_reg;
    logic m_valid_reg;
    out_t m_data_reg;
    logic s_fire;
    logic tail_fire;
    logic out_load;
    out_t tail_res;
    tok_t tail;

    assign s_ready = !busy_reg && !pend_valid_reg;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_tok_next         = '0;
        in_tok_next.valid   = s_fire;
        in_tok_next.opcode  = s_data.opcode;
        in_tok_next.address = s_data.address;
        if (s_data.opcode == OP_BAN) begin
            in_tok_next.stamp = {1'b0, s_data.now_seconds} + {2'b00, s_data.duration};
        end else begin
            in_tok_next.stamp = {1'b0, s_data.now_seconds};
        end
    end

    assign chain[0] = in_tok_reg;

    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        ibt_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .tok_i         (chain[i]),
            .tok_o         (chain[i+1]),
            .entry_valid_o (valid_vec[i])
        );
    end

    for (genvar j = 0; j <= TABLE_ENTRIES; j++) begin : g_vld
        assign tok_vld[j] = chain[j].valid;
    end

    assign tail      = chain[TABLE_ENTRIES];
    assign tail_fire = tail.valid;

    always_comb begin
        tail_res             = '0;
        tail_res.is_banned   = tail.banned;
        tail_res.was_updated = tail.updated;
        tail_res.table_full  = (tail.opcode == OP_BAN) && !tail.hit;
    end

    assign out_load = pend_valid_reg && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_tok_reg     <= '0;
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            in_tok_reg <= in_tok_next;
            if (s_fire) begin
                busy_reg <= 1'b1;
            end else if (tail_fire) begin
                busy_reg <= 1'b0;
            end
            if (tail_fire) begin
                pend_valid_reg <= 1'b1;
            end else if (out_load) begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tail_fire) begin
            pend_reg <= tail_res;
        end
        if (out_load) begin
            m_data_reg <= pend_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `IBT_ASSERT(a_one_token, $onehot0(tok_vld))
    `IBT_ASSERT(a_token_busy, (tok_vld != '0) |-> busy_reg)
    `IBT_ASSERT(a_no_pend_overrun, tail_fire |-> !pend_valid_reg)
    `IBT_ASSERT(a_fill_in_order,
        (valid_vec & (valid_vec + {{(TABLE_ENTRIES-1){1'b0}}, 1'b1})) == '0)

endmodule

// File: rtl/ibt_cell.sv
// One table entry: compare, update or claim as the item passes by.
module ibt_cell
    import ibt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  tok_t tok_i,
    output tok_t tok_o,
    output logic entry_valid_o
);

    tok_t        tok_reg;
    tok_t        tok_next;
    logic        valid_reg;
    logic [31:0] addr_reg;
    logic [32:0] end_reg;
    logic        hit_here;
    logic        claim;

    assign hit_here = tok_i.valid && !tok_i.hit && valid_reg && (addr_reg == tok_i.address);
    assign claim    = tok_i.valid && !tok_i.hit && !valid_reg && (tok_i.opcode == OP_BAN);

    always_comb begin
        tok_next = tok_i;
        if (hit_here) begin
            tok_next.hit = 1'b1;
            if (tok_i.opcode == OP_BAN) begin
                tok_next.updated = 1'b1;
            end else begin
                tok_next.banned = (tok_i.stamp < end_reg);
            end
        end
        if (claim) begin
            tok_next.hit = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            tok_reg <= tok_next;
            if (claim) begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (claim) begin
            addr_reg <= tok_i.address;
        end
        if (claim || (hit_here && (tok_i.opcode == OP_BAN))) begin
            end_reg <= tok_i.stamp;
        end
    end

    assign tok_o         = tok_reg;
    assign entry_valid_o = valid_reg;

endmodule
